// ----- design/asd_pkg.sv -----
package asd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV_DZ      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CIRCULAR    = CFG_IDX_W'(3);

  localparam logic [14:0] DEAD_ZONE_RST   = 15'd4915;
  localparam logic [15:0] INV_DZ_RST      = 16'd0;
  localparam logic [15:0] SENSITIVITY_RST = 16'd36045;
  localparam logic        CIRCULAR_RST    = 1'b1;

  // Rescales a Q.15 register value to a sample with f fractional bits.
  function automatic logic [39:0] scale_q15(logic [15:0] v, int f);
    logic [39:0] wide;
    wide = 40'(v);
    if (f >= 15) begin
      return wide << (f - 15);
    end
    return wide >> (15 - f);
  endfunction

endpackage

// ----- design/asd_if.sv -----
interface asd_in_if #(parameter int SB = 16) ();
  logic              valid;
  logic              ready;
  logic signed [SB-1:0] stick_x;
  logic signed [SB-1:0] stick_y;
  modport source (output valid, stick_x, stick_y, input ready);
  modport sink (input valid, stick_x, stick_y, output ready);
endinterface

interface asd_out_if #(parameter int SB = 16) ();
  logic              valid;
  logic              ready;
  logic signed [SB-1:0] shaped_x;
  logic signed [SB-1:0] shaped_y;
  modport source (output valid, shaped_x, shaped_y, input ready);
  modport sink (input valid, shaped_x, shaped_y, output ready);
endinterface

interface asd_cfg_if #(parameter int IW = 8, parameter int DW = 16) ();
  logic          valid;
  logic          ready;
  logic [IW-1:0] index;
  logic [DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/asd_sqrt.sv -----
module asd_sqrt import asd_pkg::*; #(
  parameter int R_W    = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [2*R_W-1:0]  a_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [R_W-1:0]    root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [R_W+1:0]    rem_q  [R_W];
  logic [R_W-1:0]    root_q [R_W];
  logic [2*R_W-1:0]  a_q    [R_W];
  logic [SIDE_W-1:0] side_q [R_W];
  logic              vld_q  [R_W];

  // One result bit per stage, two radicand bits shifted in each time.
  for (genvar k = 0; k < R_W; k++) begin : g_st
    logic [R_W+1:0]    r_in;
    logic [R_W-1:0]    o_in;
    logic [2*R_W-1:0]  a_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;
    logic [R_W+3:0]    t;
    logic [R_W+3:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign o_in = '0;
      assign a_in = a_i;
      assign s_in = side_i;
      assign v_in = vld_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign o_in = root_q[k-1];
      assign a_in = a_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = vld_q[k-1];
    end

    assign t     = {r_in, a_in[2*R_W-1 -: 2]};
    assign trial = {2'b00, o_in, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (R_W+2)'(t - trial) : t[R_W+1:0];
        root_q[k] <= {o_in[R_W-2:0], ge};
        a_q[k]    <= a_in << 2;
        side_q[k] <= s_in;
      end
    end
  end

  assign vld_o  = vld_q[R_W-1];
  assign root_o = root_q[R_W-1];
  assign side_o = side_q[R_W-1];

endmodule

// ----- design/asd_div.sv -----
module asd_div import asd_pkg::*; #(
  parameter int DEN_W  = 16,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [Q_W-1:0]    lo_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [Q_W-1:0]    q_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [Q_W-1:0]    lo_q   [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];
  logic              vld_q  [Q_W];

  // Restoring division: the low dividend bits shift out at the top while the
  // quotient bits shift in at the bottom. The caller keeps the upper part
  // of the dividend below the divisor.
  for (genvar k = 0; k < Q_W; k++) begin : g_st
    logic [DEN_W-1:0]  r_in;
    logic [Q_W-1:0]    l_in;
    logic [DEN_W-1:0]  d_in;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;
    logic [DEN_W:0]    tr;
    logic              ge;

    if (k == 0) begin : g_first
      assign r_in = rem_i;
      assign l_in = lo_i;
      assign d_in = den_i;
      assign s_in = side_i;
      assign v_in = vld_i;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign l_in = lo_q[k-1];
      assign d_in = den_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = vld_q[k-1];
    end

    assign tr = {r_in, l_in[Q_W-1]};
    assign ge = tr >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DEN_W'(tr - {1'b0, d_in}) : tr[DEN_W-1:0];
        lo_q[k]   <= {l_in[Q_W-2:0], ge};
        den_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign vld_o  = vld_q[Q_W-1];
  assign q_o    = lo_q[Q_W-1];
  assign side_o = side_q[Q_W-1];

endmodule

// ----- design/analog_stick_deadzone_shaper_unit.sv -----
// Depth: 3*SAMPLE_BITS+6 register stages between an accepted request and its registered result.
// Throughput: one request per cycle while the output is not stalled; the pipelined square root
// and dividers set the depth.
// A held result stalls the whole pipeline in place, nothing is dropped or repeated.
// Reset is asynchronous and active low: it clears all valid bits and loads the
// register reset values.
module analog_stick_deadzone_shaper_unit import asd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  asd_cfg_if.sink   cfg_i,
  asd_in_if.sink    stick_i,
  asd_out_if.source shaped_o
);

  localparam int F  = SAMPLE_BITS - 1;
  localparam int W1 = SAMPLE_BITS;
  localparam int PW = 2 * W1 + 3;
  localparam logic [W1-1:0] ONE     = {1'b1, {F{1'b0}}};
  localparam logic [W1-1:0] ONE_M1  = {1'b0, {F{1'b1}}};
  localparam int SQ_SIDE = 2 + 3 * W1;
  localparam int V_SIDE  = 4 + 3 * W1;

  // Configuration registers.
  logic [14:0] dz_q;
  logic [15:0] inv_q;
  logic [15:0] sens_q;
  logic        circ_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q   <= DEAD_ZONE_RST;
      inv_q  <= INV_DZ_RST;
      sens_q <= SENSITIVITY_RST;
      circ_q <= CIRCULAR_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DEAD_ZONE:   dz_q   <= cfg_i.data[14:0];
        REG_INV_DZ:      inv_q  <= cfg_i.data[15:0];
        REG_SENSITIVITY: sens_q <= cfg_i.data[15:0];
        REG_CIRCULAR:    circ_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  logic [F-1:0] d_s;
  logic [W1:0]  inv_s;
  logic [W1:0]  sen_s;

  assign d_s   = F'(scale_q15({1'b0, dz_q}, F));
  assign inv_s = (W1+1)'(scale_q15(inv_q, F));
  assign sen_s = (W1+1)'(scale_q15(sens_q, F));

  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || shaped_o.ready;
  assign stick_i.ready = en;

  // Stage 0: magnitudes and signs.
  logic          p0_vld_q;
  logic          p0_sx_q, p0_sy_q;
  logic [W1-1:0] p0_ax_q, p0_ay_q;
  logic [W1-1:0] ax_d, ay_d;

  assign ax_d = stick_i.stick_x[F] ? W1'(0) - W1'(stick_i.stick_x) : W1'(stick_i.stick_x);
  assign ay_d = stick_i.stick_y[F] ? W1'(0) - W1'(stick_i.stick_y) : W1'(stick_i.stick_y);

  // Stage 1: sum of squares and the larger magnitude.
  logic            p1_vld_q;
  logic [2*W1-1:0] p1_sum_q;
  logic [SQ_SIDE-1:0] p1_side_q;
  logic [2*W1-1:0] sum_d;
  logic [W1-1:0]   m_d;

  assign sum_d = (2*W1)'(p0_ax_q) * (2*W1)'(p0_ax_q) + (2*W1)'(p0_ay_q) * (2*W1)'(p0_ay_q);
  assign m_d   = (p0_ax_q > p0_ay_q) ? p0_ax_q : p0_ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q <= 1'b0;
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p0_vld_q <= stick_i.valid;
      p1_vld_q <= p0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_sx_q   <= stick_i.stick_x[F];
      p0_sy_q   <= stick_i.stick_y[F];
      p0_ax_q   <= ax_d;
      p0_ay_q   <= ay_d;
      p1_sum_q  <= sum_d;
      p1_side_q <= {p0_sx_q, p0_sy_q, p0_ax_q, p0_ay_q, m_d};
    end
  end

  // Square root of the sum of squares.
  logic               sq_vld;
  logic [W1-1:0]      sq_root;
  logic [SQ_SIDE-1:0] sq_side;

  asd_sqrt #(
    .R_W    (W1),
    .SIDE_W (SQ_SIDE)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p1_vld_q),
    .a_i    (p1_sum_q),
    .side_i (p1_side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // Stage 2: deadzone removal, set up the rescaling division.
  logic          p2_vld_q;
  logic [W1-1:0] p2_rem_q;
  logic [W1-1:0] p2_den_q;
  logic [V_SIDE-1:0] p2_side_q;
  logic [W1-1:0] m2, n2, diff2, den2;
  logic          vzero2, sat2;

  assign m2     = sq_side[W1-1:0];
  assign n2     = circ_q ? sq_root : m2;
  assign vzero2 = n2 <= W1'(d_s);
  assign diff2  = n2 - W1'(d_s);
  assign den2   = ONE - W1'(d_s);
  assign sat2   = diff2 >= den2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_rem_q  <= (vzero2 || sat2) ? W1'(0) : diff2;
      p2_den_q  <= den2;
      p2_side_q <= {vzero2, sat2, sq_side};
    end
  end

  logic              vd_vld;
  logic [F-1:0]      vd_q;
  logic [V_SIDE-1:0] vd_side;

  asd_div #(
    .DEN_W  (W1),
    .Q_W    (F),
    .SIDE_W (V_SIDE)
  ) u_div_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p2_vld_q),
    .rem_i  (p2_rem_q),
    .lo_i   ('0),
    .den_i  (p2_den_q),
    .side_i (p2_side_q),
    .vld_o  (vd_vld),
    .q_o    (vd_q),
    .side_o (vd_side)
  );

  // Stage 3: ramp slope product.
  logic               p3_vld_q;
  logic signed [PW-1:0] p3_prod_q;
  logic               p3_vnz_q;
  logic [SQ_SIDE-1:0] p3_side_q;
  logic [W1-1:0]      v3;
  logic signed [W1+1:0] sd3;

  always_comb begin
    if (vd_side[V_SIDE-1]) begin
      v3 = '0;
    end else if (vd_side[V_SIDE-2]) begin
      v3 = ONE;
    end else begin
      v3 = {1'b0, vd_q};
    end
  end

  assign sd3 = signed'({1'b0, sen_s}) - signed'({1'b0, inv_s});

  // Stage 4: offset, floor division by one and clamp.
  logic               p4_vld_q;
  logic [W1-1:0]      p4_w_q;
  logic [SQ_SIDE-1:0] p4_side_q;
  logic signed [PW-1:0] num4;
  logic [PW-F-1:0]    wt4;
  logic [W1-1:0]      w4;

  assign num4 = signed'(PW'({inv_s, {F{1'b0}}})) + p3_prod_q;
  assign wt4  = num4[PW-1:F];

  always_comb begin
    if (!p3_vnz_q || num4 <= 0) begin
      w4 = '0;
    end else if (wt4 > (PW-F)'(ONE)) begin
      w4 = ONE;
    end else begin
      w4 = wt4[W1-1:0];
    end
  end

  // Stage 5: scale each axis magnitude by the mapped norm.
  logic            p5_vld_q;
  logic [2*W1-1:0] p5_px_q, p5_py_q;
  logic [W1-1:0]   p5_m_q;
  logic            p5_sx_q, p5_sy_q, p5_zero_q;
  logic [W1-1:0]   ax4, ay4, m4;

  assign ax4 = p4_side_q[3*W1-1:2*W1];
  assign ay4 = p4_side_q[2*W1-1:W1];
  assign m4  = p4_side_q[W1-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      p5_vld_q <= 1'b0;
    end else if (en) begin
      p3_vld_q <= vd_vld;
      p4_vld_q <= p3_vld_q;
      p5_vld_q <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_prod_q <= PW'(signed'({1'b0, v3}) * sd3);
      p3_vnz_q  <= v3 != '0;
      p3_side_q <= vd_side[SQ_SIDE-1:0];
      p4_w_q    <= w4;
      p4_side_q <= p3_side_q;
      p5_px_q   <= (2*W1)'(ax4) * (2*W1)'(p4_w_q);
      p5_py_q   <= (2*W1)'(ay4) * (2*W1)'(p4_w_q);
      p5_m_q    <= m4;
      p5_sx_q   <= p4_side_q[SQ_SIDE-1];
      p5_sy_q   <= p4_side_q[SQ_SIDE-2];
      p5_zero_q <= m4 == '0;
    end
  end

  // Per-axis division by the larger magnitude.
  logic          dx_vld, dy_vld;
  logic [W1-1:0] dx_q, dy_q;
  logic [1:0]    dx_side;
  logic          dy_side;

  asd_div #(
    .DEN_W  (W1),
    .Q_W    (W1),
    .SIDE_W (2)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p5_vld_q),
    .rem_i  (p5_px_q[2*W1-1:W1]),
    .lo_i   (p5_px_q[W1-1:0]),
    .den_i  (p5_m_q),
    .side_i ({p5_zero_q, p5_sx_q}),
    .vld_o  (dx_vld),
    .q_o    (dx_q),
    .side_o (dx_side)
  );

  asd_div #(
    .DEN_W  (W1),
    .Q_W    (W1),
    .SIDE_W (1)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p5_vld_q),
    .rem_i  (p5_py_q[2*W1-1:W1]),
    .lo_i   (p5_py_q[W1-1:0]),
    .den_i  (p5_m_q),
    .side_i (p5_sy_q),
    .vld_o  (dy_vld),
    .q_o    (dy_q),
    .side_o (dy_side)
  );

  // Output stage: saturate, restore the sign, force a zero sample to zero.
  logic [W1-1:0] out_x_q, out_y_q;
  logic [W1-1:0] magx, magy;

  assign magx = (dx_q > ONE_M1) ? ONE_M1 : dx_q;
  assign magy = (dy_q > ONE_M1) ? ONE_M1 : dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dx_vld && dy_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dx_side[1]) begin
        out_x_q <= '0;
        out_y_q <= '0;
      end else begin
        out_x_q <= dx_side[0] ? W1'(0) - magx : magx;
        out_y_q <= dy_side ? W1'(0) - magy : magy;
      end
    end
  end

  assign shaped_o.valid    = out_vld_q;
  assign shaped_o.shaped_x = signed'(out_x_q);
  assign shaped_o.shaped_y = signed'(out_y_q);

endmodule

// ----- design/asd_chk.sv -----
module asd_chk import asd_pkg::*; #(
  parameter int SB = SAMPLE_BITS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [SB-1:0] out_x_i,
  input logic [SB-1:0] out_y_i
);

  localparam logic [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};

  // The pipeline advances exactly when the result slot is free or being taken.
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow the output slot");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_x_i != MOST_NEG && out_y_i != MOST_NEG))
    else $error("result outside the saturation range");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result shown straight after reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("stalled result withdrawn");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_x_i) && $stable(out_y_i)))
    else $error("stalled result changed");

endmodule

bind analog_stick_deadzone_shaper_unit asd_chk #(
  .SB (SAMPLE_BITS)
) u_asd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (stick_i.ready),
  .out_valid_i (shaped_o.valid),
  .out_ready_i (shaped_o.ready),
  .out_x_i     (shaped_o.shaped_x),
  .out_y_i     (shaped_o.shaped_y)
);
